[sv/fade_curve_table_lookup_assert.svh]
// Assertion macros shared by the checker of the fade curve table lookup.
`ifndef FADE_CURVE_TABLE_LOOKUP_ASSERT_SVH
`define FADE_CURVE_TABLE_LOOKUP_ASSERT_SVH

// Checked at every clock edge, quiet while reset is asserted.
`define FCTL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FCTL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/fctl_pkg.sv]
// Types, constants and codes shared by the fade curve table lookup modules.
`default_nettype none

package fctl_pkg;

    // Default table depth.
    localparam int TABLE_SIZE_DEF = 1024;

    // Fixed-point formats.
    localparam logic [16:0] ANGLE_ONE  = 17'd65536;
    localparam logic [16:0] ANGLE_HALF = 17'd32768;
    localparam logic [15:0] LEVEL_ONE  = 16'd32768;

    // Odd sine polynomial coefficients, Q30.
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172272;

    // Curve shape codes.
    localparam logic [1:0] SHAPE_SINE   = 2'd0;
    localparam logic [1:0] SHAPE_LINEAR = 2'd1;
    localparam logic [1:0] SHAPE_RAISED = 2'd2;
    localparam logic [1:0] SHAPE_KEEP   = 2'd3;

    // Command codes.
    localparam logic CMD_REBUILD = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_REC_SHAPE        = 3'd0,
        CFG_PRE_SHAPE        = 3'd1,
        CFG_REC_DELAY_MIN    = 3'd2,
        CFG_REC_DELAY_RATIO  = 3'd3,
        CFG_PRE_WINDOW_MIN   = 3'd4,
        CFG_PRE_WINDOW_RATIO = 3'd5
    } fctl_cfg_idx_t;

    // Configuration reset values.
    localparam logic [1:0]  REC_SHAPE_RST        = 2'd2;
    localparam logic [1:0]  PRE_SHAPE_RST        = 2'd1;
    localparam logic [10:0] REC_DELAY_MIN_RST    = 11'd0;
    localparam logic [15:0] REC_DELAY_RATIO_RST  = 16'd512;
    localparam logic [10:0] PRE_WINDOW_MIN_RST   = 11'd0;
    localparam logic [15:0] PRE_WINDOW_RATIO_RST = 16'd8192;

    // Input word.
    typedef struct packed {
        logic        cmd;
        logic [16:0] phase;
    } fctl_item_t;

    // Output word.
    typedef struct packed {
        logic [15:0] rec_level;
        logic [15:0] pre_level;
    } fctl_result_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } fctl_div_status_t;

endpackage

`default_nettype wire

[sv/fctl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fctl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/fctl_div.sv]
// Bit-serial restoring divider of the constant 65536 by a table span.
`default_nettype none

module fctl_div
    import fctl_pkg::*;
#(
    parameter int DIV_W = 11
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] divisor,
    output fctl_div_status_t      status,
    output logic      [16:0]      quot,
    output logic      [DIV_W-1:0] rem
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [16:0]      quo_reg, quo_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W:0]   trial;
    logic             fits;

    // One quotient bit per cycle, most significant first.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[16]};
        fits      = (trial >= {1'b0, div_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd17;
            rem_next  = '0;
            quo_next  = ANGLE_ONE;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
            quo_next = {quo_reg[15:0], fits};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = quo_reg;
    assign rem         = rem_reg;

endmodule

`default_nettype wire

[sv/fade_curve_table_lookup.sv]
// Fade curve tables with a rebuild sequencer and an interpolating lookup.
//
//   Channel | Direction | Handshake                 | Word
//   item    | in        | item_valid / item_ready   | fctl_item_t (cmd, phase)
//   result  | out       | result_valid / result_ready | fctl_result_t (levels)
//   cfg     | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A lookup steps through LK_RD0, LK_RD1 and LK_SUM to DONE, which presents
// its result once the output is free and returns to idle for the next word:
// two reads of each table on its single read port, then two multiplies and
// an add per table. In a rebuild, each entry runs two sine evaluations
// through one shared multiplier, six products apiece.
// Reset clears control only; the tables hold nothing until the first rebuild.
// A result waiting on result_ready does not block the next item from entering.
`default_nettype none

module fade_curve_table_lookup
    import fctl_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    output logic              item_ready,
    input  wire fctl_item_t   item,
    output logic              result_valid,
    input  wire logic         result_ready,
    output fctl_result_t      result,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int VW = AW + 1;
    localparam int MW = (VW > 11) ? VW : 11;
    localparam int PW = 17 + AW;
    localparam int DW = 16 + VW;

    localparam logic [AW-1:0] IDX_LAST   = AW'(TABLE_SIZE - 1);
    localparam logic [AW-1:0] IDX_PENULT = AW'(TABLE_SIZE - 2);
    localparam logic [VW-1:0] LAST_V     = VW'(TABLE_SIZE - 1);
    localparam logic [MW-1:0] SIZE_M     = MW'(TABLE_SIZE);
    localparam logic [MW-1:0] PENULT_M   = MW'(TABLE_SIZE - 2);
    localparam logic [MW-1:0] ONE_M      = MW'(1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_LK_RD0   = 9'b000000010,
        ST_LK_RD1   = 9'b000000100,
        ST_LK_SUM   = 9'b000001000,
        ST_RB_SETUP = 9'b000010000,
        ST_RB_DIVR  = 9'b000100000,
        ST_RB_DIVW  = 9'b001000000,
        ST_RB_SIN   = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    // Control registers.
    state_t       state_reg, state_next;
    logic         result_valid_reg, result_valid_next;
    logic         div_start_reg, div_start_next;
    logic [1:0]   rec_shape_reg, pre_shape_reg;
    logic [10:0]  rec_delay_min_reg, pre_window_min_reg;
    logic [15:0]  rec_delay_ratio_reg, pre_window_ratio_reg;

    // Datapath registers.
    fctl_result_t result_reg, result_next;
    fctl_result_t res_reg, res_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [16:0]   frac_reg, frac_next;
    logic [32:0]   rec_acc_reg, rec_acc_next;
    logic [32:0]   pre_acc_reg, pre_acc_next;
    logic [AW-1:0] d_reg, d_next;
    logic [VW-1:0] r_reg, r_next;
    logic [VW-1:0] w_reg, w_next;
    logic [16:0]   rq_reg, rq_next;
    logic [VW-1:0] rrm_reg, rrm_next;
    logic [16:0]   wq_reg, wq_next;
    logic [VW-1:0] wrm_reg, wrm_next;
    logic [AW-1:0] i_reg, i_next;
    logic          sel_pre_reg, sel_pre_next;
    logic [2:0]    sstep_reg, sstep_next;
    logic [16:0]   a_reg, a_next;
    logic [16:0]   t2_reg, t2_next;
    logic [47:0]   prod_reg, prod_next;
    logic [15:0]   rec_val_reg, rec_val_next;
    logic [16:0]   rec_u_reg, rec_u_next;
    logic [VW-1:0] rec_rem_reg, rec_rem_next;
    logic [16:0]   pre_u_reg, pre_u_next;
    logic [VW-1:0] pre_rem_reg, pre_rem_next;

    // Combinational helpers.
    logic [16:0]   phase_sat;
    logic [PW-1:0] pos;
    logic [VW-1:0] idx_full;
    logic [DW-1:0] dprod, wprod;
    logic [MW-1:0] dmax, dclamp, wmax, wclamp;
    logic [16:0]   cur_u;
    logic [1:0]    cur_shape;
    logic [16:0]   angle;
    logic [16:0]   mul_x;
    logic [30:0]   mul_y;
    logic [30:0]   coef;
    logic [47:0]   sin_round;
    logic [16:0]   sin_raw;
    logic [15:0]   sin_val;
    logic [16:0]   half_sum;
    logic [15:0]   half_plus, half_minus;
    logic [15:0]   rec_value, pre_value;
    logic [VW:0]   rec_step, pre_step;
    logic [33:0]   rec_sum, pre_sum;

    // Memory ports.
    logic          rec_we, pre_we;
    logic [AW-1:0] raddr;
    logic [15:0]   rec_rdata, pre_rdata;

    // Divider.
    fctl_div_status_t div_status;
    logic [VW-1:0]    div_divisor;
    logic [16:0]      div_quot;
    logic [VW-1:0]    div_rem;

    assign div_divisor = (state_reg == ST_RB_DIVW) ? w_reg : r_reg;

    fctl_div #(
        .DIV_W (VW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start_reg),
        .divisor (div_divisor),
        .status  (div_status),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // Curve tables. Rebuild only writes and lookup only reads, so no
    // access to one entry ever overlaps another.
    assign raddr = (state_reg == ST_LK_RD1) ? AW'(idx_reg + 1'b1) : idx_reg;

    fctl_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_SIZE)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (i_reg),
        .wdata (rec_val_reg),
        .raddr (raddr),
        .rdata (rec_rdata)
    );

    fctl_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_SIZE)
    ) u_pre_ram (
        .clk   (clk),
        .we    (pre_we),
        .waddr (i_reg),
        .wdata (pre_value),
        .raddr (raddr),
        .rdata (pre_rdata)
    );

    // Lookup position: index and fraction of the saturated phase.
    always_comb
    begin
        phase_sat = (item.phase > ANGLE_ONE) ? ANGLE_ONE : item.phase;
        pos       = PW'(phase_sat) * PW'(TABLE_SIZE - 1);
        idx_full  = pos[PW-1:16];
    end

    // Delay and window sizes from the configuration.
    always_comb
    begin
        dprod  = DW'(rec_delay_ratio_reg) * DW'(TABLE_SIZE);
        dmax   = (MW'(rec_delay_min_reg) > MW'(dprod[DW-1:16])) ?
                 MW'(rec_delay_min_reg) : MW'(dprod[DW-1:16]);
        dclamp = (dmax > PENULT_M) ? PENULT_M : dmax;
        wprod  = DW'(pre_window_ratio_reg) * DW'(TABLE_SIZE);
        wmax   = (MW'(pre_window_min_reg) > MW'(wprod[DW-1:16])) ?
                 MW'(pre_window_min_reg) : MW'(wprod[DW-1:16]);
        if (wmax < ONE_M)
        begin
            wclamp = ONE_M;
        end
        else if (wmax > SIZE_M)
        begin
            wclamp = SIZE_M;
        end
        else
        begin
            wclamp = wmax;
        end
    end

    // Sine angle for the curve now being evaluated.
    always_comb
    begin
        cur_u     = sel_pre_reg ? pre_u_reg : rec_u_reg;
        cur_shape = sel_pre_reg ? pre_shape_reg : rec_shape_reg;
        if (cur_shape == SHAPE_SINE)
        begin
            angle = (cur_u <= ANGLE_HALF) ? 17'(ANGLE_ONE - (cur_u << 1)) :
                                            17'((cur_u << 1) - ANGLE_ONE);
        end
        else if (cur_shape == SHAPE_RAISED && sel_pre_reg)
        begin
            angle = ANGLE_ONE - cur_u;
        end
        else
        begin
            angle = cur_u;
        end
    end

    // Horner coefficient for each multiply step.
    always_comb
    begin
        case (sstep_reg)
            3'd2:    coef = SIN_C7;
            3'd3:    coef = SIN_C5;
            3'd4:    coef = SIN_C3;
            3'd5:    coef = SIN_C1;
            default: coef = SIN_C9;
        endcase
    end

    // Shared multiplier operands: a*a, then t2*p four times, then a*p.
    always_comb
    begin
        case (sstep_reg)
            3'd0:
            begin
                mul_x = angle;
                mul_y = 31'(angle);
            end
            3'd1:
            begin
                mul_x = prod_reg[32:16];
                mul_y = SIN_C9;
            end
            3'd5:
            begin
                mul_x = a_reg;
                mul_y = coef - prod_reg[46:16];
            end
            default:
            begin
                mul_x = t2_reg;
                mul_y = coef - prod_reg[46:16];
            end
        endcase
    end

    // Rounded sine and the curve values built from it.
    always_comb
    begin
        sin_round  = prod_reg + 48'h0000_4000_0000;
        sin_raw    = sin_round[47:31];
        sin_val    = (sin_raw > 17'(LEVEL_ONE)) ? LEVEL_ONE : sin_raw[15:0];
        half_sum   = 17'(LEVEL_ONE) + 17'(sin_val);
        half_plus  = half_sum[16:1];
        half_minus = 16'((LEVEL_ONE - sin_val) >> 1);

        if (i_reg == IDX_LAST)
        begin
            rec_value = LEVEL_ONE;
        end
        else if (i_reg < d_reg)
        begin
            rec_value = '0;
        end
        else
        begin
            case (rec_shape_reg)
                SHAPE_SINE:   rec_value = (rec_u_reg <= ANGLE_HALF) ? half_minus : half_plus;
                SHAPE_LINEAR: rec_value = rec_u_reg[16:1];
                default:      rec_value = sin_val;
            endcase
        end

        if (VW'(i_reg) < w_reg)
        begin
            case (pre_shape_reg)
                SHAPE_SINE:   pre_value = (pre_u_reg <= ANGLE_HALF) ? half_plus : half_minus;
                SHAPE_LINEAR: pre_value = LEVEL_ONE - pre_u_reg[16:1];
                default:      pre_value = sin_val;
            endcase
        end
        else
        begin
            pre_value = '0;
        end

        rec_step = {1'b0, rec_rem_reg} + {1'b0, rrm_reg};
        pre_step = {1'b0, pre_rem_reg} + {1'b0, wrm_reg};
    end

    // Interpolation sums of the second table reads.
    always_comb
    begin
        rec_sum = 34'(rec_acc_reg) + 34'(33'(rec_rdata) * 33'(frac_reg));
        pre_sum = 34'(pre_acc_reg) + 34'(33'(pre_rdata) * 33'(frac_reg));
    end

    // Table writes happen once both values of an entry are known.
    assign rec_we = (state_reg == ST_RB_SIN) && sel_pre_reg && (sstep_reg == 3'd6) &&
                    (rec_shape_reg != SHAPE_KEEP);
    assign pre_we = (state_reg == ST_RB_SIN) && sel_pre_reg && (sstep_reg == 3'd6) &&
                    (pre_shape_reg != SHAPE_KEEP);

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        div_start_next    = 1'b0;
        res_next          = res_reg;
        idx_next          = idx_reg;
        frac_next         = frac_reg;
        rec_acc_next      = rec_acc_reg;
        pre_acc_next      = pre_acc_reg;
        d_next            = d_reg;
        r_next            = r_reg;
        w_next            = w_reg;
        rq_next           = rq_reg;
        rrm_next          = rrm_reg;
        wq_next           = wq_reg;
        wrm_next          = wrm_reg;
        i_next            = i_reg;
        sel_pre_next      = sel_pre_reg;
        sstep_next        = sstep_reg;
        a_next            = a_reg;
        t2_next           = t2_reg;
        prod_next         = prod_reg;
        rec_val_next      = rec_val_reg;
        rec_u_next        = rec_u_reg;
        rec_rem_next      = rec_rem_reg;
        pre_u_next        = pre_u_reg;
        pre_rem_next      = pre_rem_reg;

        // The output word leaves when taken.
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.cmd == CMD_LOOKUP)
                    begin
                        if (idx_full >= LAST_V)
                        begin
                            idx_next  = IDX_PENULT;
                            frac_next = ANGLE_ONE;
                        end
                        else
                        begin
                            idx_next  = idx_full[AW-1:0];
                            frac_next = {1'b0, pos[15:0]};
                        end
                        state_next = ST_LK_RD0;
                    end
                    else
                    begin
                        state_next = ST_RB_SETUP;
                    end
                end
            end
            ST_LK_RD0:
            begin
                state_next = ST_LK_RD1;
            end
            ST_LK_RD1:
            begin
                rec_acc_next = 33'(rec_rdata) * 33'(ANGLE_ONE - frac_reg);
                pre_acc_next = 33'(pre_rdata) * 33'(ANGLE_ONE - frac_reg);
                state_next   = ST_LK_SUM;
            end
            ST_LK_SUM:
            begin
                res_next.rec_level = rec_sum[31:16];
                res_next.pre_level = pre_sum[31:16];
                state_next         = ST_DONE;
            end
            ST_RB_SETUP:
            begin
                d_next         = dclamp[AW-1:0];
                r_next         = LAST_V - VW'(dclamp);
                w_next         = wclamp[VW-1:0];
                div_start_next = 1'b1;
                state_next     = ST_RB_DIVR;
            end
            ST_RB_DIVR:
            begin
                if (div_status.done)
                begin
                    rq_next        = div_quot;
                    rrm_next       = div_rem;
                    div_start_next = 1'b1;
                    state_next     = ST_RB_DIVW;
                end
            end
            ST_RB_DIVW:
            begin
                if (div_status.done)
                begin
                    wq_next      = div_quot;
                    wrm_next     = div_rem;
                    i_next       = '0;
                    sel_pre_next = 1'b0;
                    sstep_next   = '0;
                    rec_u_next   = '0;
                    rec_rem_next = '0;
                    pre_u_next   = '0;
                    pre_rem_next = '0;
                    state_next   = ST_RB_SIN;
                end
            end
            ST_RB_SIN:
            begin
                if (sstep_reg != 3'd6)
                begin
                    prod_next  = 48'(mul_x) * 48'(mul_y);
                    sstep_next = sstep_reg + 3'd1;
                    if (sstep_reg == 3'd0)
                    begin
                        a_next = angle;
                    end
                    if (sstep_reg == 3'd1)
                    begin
                        t2_next = prod_reg[32:16];
                    end
                end
                else if (!sel_pre_reg)
                begin
                    rec_val_next = rec_value;
                    sel_pre_next = 1'b1;
                    sstep_next   = '0;
                end
                else
                begin
                    // Entry written; step both angle accumulators.
                    if (i_reg >= d_reg && i_reg != IDX_LAST)
                    begin
                        if (rec_step >= {1'b0, r_reg})
                        begin
                            rec_rem_next = VW'(rec_step - {1'b0, r_reg});
                            rec_u_next   = rec_u_reg + rq_reg + 17'd1;
                        end
                        else
                        begin
                            rec_rem_next = rec_step[VW-1:0];
                            rec_u_next   = rec_u_reg + rq_reg;
                        end
                    end
                    if (VW'(i_reg) < w_reg)
                    begin
                        if (pre_step >= {1'b0, w_reg})
                        begin
                            pre_rem_next = VW'(pre_step - {1'b0, w_reg});
                            pre_u_next   = pre_u_reg + wq_reg + 17'd1;
                        end
                        else
                        begin
                            pre_rem_next = pre_step[VW-1:0];
                            pre_u_next   = pre_u_reg + wq_reg;
                        end
                    end
                    sel_pre_next = 1'b0;
                    sstep_next   = '0;
                    i_next       = i_reg + 1'b1;
                    if (i_reg == IDX_LAST)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next       = res_reg;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            result_valid_reg     <= 1'b0;
            div_start_reg        <= 1'b0;
            rec_shape_reg        <= REC_SHAPE_RST;
            pre_shape_reg        <= PRE_SHAPE_RST;
            rec_delay_min_reg    <= REC_DELAY_MIN_RST;
            rec_delay_ratio_reg  <= REC_DELAY_RATIO_RST;
            pre_window_min_reg   <= PRE_WINDOW_MIN_RST;
            pre_window_ratio_reg <= PRE_WINDOW_RATIO_RST;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            div_start_reg    <= div_start_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_REC_SHAPE:        rec_shape_reg        <= cfg_data[1:0];
                    CFG_PRE_SHAPE:        pre_shape_reg        <= cfg_data[1:0];
                    CFG_REC_DELAY_MIN:    rec_delay_min_reg    <= cfg_data[10:0];
                    CFG_REC_DELAY_RATIO:  rec_delay_ratio_reg  <= cfg_data;
                    CFG_PRE_WINDOW_MIN:   pre_window_min_reg   <= cfg_data[10:0];
                    CFG_PRE_WINDOW_RATIO: pre_window_ratio_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        res_reg     <= res_next;
        idx_reg     <= idx_next;
        frac_reg    <= frac_next;
        rec_acc_reg <= rec_acc_next;
        pre_acc_reg <= pre_acc_next;
        d_reg       <= d_next;
        r_reg       <= r_next;
        w_reg       <= w_next;
        rq_reg      <= rq_next;
        rrm_reg     <= rrm_next;
        wq_reg      <= wq_next;
        wrm_reg     <= wrm_next;
        i_reg       <= i_next;
        sel_pre_reg <= sel_pre_next;
        sstep_reg   <= sstep_next;
        a_reg       <= a_next;
        t2_reg      <= t2_next;
        prod_reg    <= prod_next;
        rec_val_reg <= rec_val_next;
        rec_u_reg   <= rec_u_next;
        rec_rem_reg <= rec_rem_next;
        pre_u_reg   <= pre_u_next;
        pre_rem_reg <= pre_rem_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire

[sv/fctl_chk.sv]
// Port-level checker for the fade curve table lookup, bound to the top level.
`default_nettype none
`include "fade_curve_table_lookup_assert.svh"

module fctl_chk
    import fctl_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         item_valid,
    input wire logic         item_ready,
    input wire logic         result_valid,
    input wire logic         result_ready,
    input wire fctl_result_t result
);

    logic [1:0] outstanding_reg, outstanding_next;
    logic       item_acc, result_acc;

    // Words accepted whose results have not yet been taken.
    always_comb
    begin
        item_acc         = item_valid && item_ready;
        result_acc       = result_valid && result_ready;
        outstanding_next = outstanding_reg + {1'b0, item_acc} - {1'b0, result_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A stalled result word holds.
    `FCTL_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result word changed while stalled")

    // No result without an accepted word behind it.
    `FCTL_ASSERT_ALWAYS(a_no_spurious, result_valid |-> outstanding_reg != 2'd0, "result with no pending word")

    // At most one word in work and one waiting at the output.
    `FCTL_ASSERT(a_depth, outstanding_reg <= 2'd2, "too many words in flight")

    // Levels never exceed unity.
    `FCTL_ASSERT(a_level_range, result_valid |-> result.rec_level <= LEVEL_ONE && result.pre_level <= LEVEL_ONE, "level above unity")

endmodule

bind fade_curve_table_lookup fctl_chk u_fctl_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

[tb/tb_top.sv]
// Testbench for the fade curve table lookup: curve prediction, scoreboard and stimulus.
`default_nettype none

// Scoreboard that mirrors both curve tables and predicts every result word.
class fade_scoreboard;
    localparam int N = fctl_pkg::TABLE_SIZE_DEF;

    logic [15:0] rec_tbl [N];
    logic [15:0] pre_tbl [N];
    logic [1:0]  rec_shape;
    logic [1:0]  pre_shape;
    logic [10:0] rec_delay_min;
    logic [15:0] rec_delay_ratio;
    logic [10:0] pre_window_min;
    logic [15:0] pre_window_ratio;
    fctl_pkg::fctl_result_t level_q [$];
    int errors;
    int rebuilds;
    int lookups;

    function new();
        rec_shape        = fctl_pkg::REC_SHAPE_RST;
        pre_shape        = fctl_pkg::PRE_SHAPE_RST;
        rec_delay_min    = fctl_pkg::REC_DELAY_MIN_RST;
        rec_delay_ratio  = fctl_pkg::REC_DELAY_RATIO_RST;
        pre_window_min   = fctl_pkg::PRE_WINDOW_MIN_RST;
        pre_window_ratio = fctl_pkg::PRE_WINDOW_RATIO_RST;
        errors   = 0;
        rebuilds = 0;
        lookups  = 0;
    endfunction

    // Register write as the block sees it; unknown indexes are ignored.
    function void write_reg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            fctl_pkg::CFG_REC_SHAPE:        rec_shape        = data[1:0];
            fctl_pkg::CFG_PRE_SHAPE:        pre_shape        = data[1:0];
            fctl_pkg::CFG_REC_DELAY_MIN:    rec_delay_min    = data[10:0];
            fctl_pkg::CFG_REC_DELAY_RATIO:  rec_delay_ratio  = data;
            fctl_pkg::CFG_PRE_WINDOW_MIN:   pre_window_min   = data[10:0];
            fctl_pkg::CFG_PRE_WINDOW_RATIO: pre_window_ratio = data;
            default: ;
        endcase
    endfunction

    // Quarter-wave sine of a Q1.16 angle, polynomial in Horner form, Q1.15 out.
    function longint quarter_sine(longint unsigned a);
        longint unsigned t2, p, r;
        if (a > 65536) a = 65536;
        t2 = (a * a) >> 16;
        p = 172272;
        p = 64'd5026995 - ((t2 * p) >> 16);
        p = 64'd85569306 - ((t2 * p) >> 16);
        p = 64'd693598668 - ((t2 * p) >> 16);
        p = 64'd1686629713 - ((t2 * p) >> 16);
        r = (a * p + (64'd1 << 30)) >> 31;
        if (r > 32768) r = 32768;
        return longint'(r);
    endfunction

    // Half-wave cosine, signed Q1.15.
    function longint half_cosine(longint unsigned u);
        if (u > 65536) u = 65536;
        if (u <= 32768) return quarter_sine(65536 - 2 * u);
        return -quarter_sine(2 * u - 65536);
    endfunction

    function void rebuild_tables();
        longint unsigned d, r, w, k, u;
        longint v;
        d = (longint'(rec_delay_ratio) * N) >> 16;
        if (rec_delay_min > d) d = rec_delay_min;
        if (d > N - 2) d = N - 2;
        r = N - 1 - d;
        if (rec_shape != fctl_pkg::SHAPE_KEEP) begin
            for (int i = 0; i < N - 1; i++) begin
                v = 0;
                if (i >= d) begin
                    k = i - d;
                    u = (k * 65536) / r;
                    if (rec_shape == fctl_pkg::SHAPE_SINE)
                        v = (32768 - half_cosine(u)) >>> 1;
                    else if (rec_shape == fctl_pkg::SHAPE_LINEAR)
                        v = longint'((k * 32768) / r);
                    else
                        v = quarter_sine(u);
                end
                rec_tbl[i] = v[15:0];
            end
            rec_tbl[N - 1] = fctl_pkg::LEVEL_ONE;
        end
        w = (longint'(pre_window_ratio) * N) >> 16;
        if (pre_window_min > w) w = pre_window_min;
        if (w < 1) w = 1;
        if (w > N) w = N;
        if (pre_shape != fctl_pkg::SHAPE_KEEP) begin
            for (int i = 0; i < N; i++) begin
                v = 0;
                if (i < w) begin
                    u = (longint'(i) * 65536) / w;
                    if (pre_shape == fctl_pkg::SHAPE_SINE)
                        v = (32768 + half_cosine(u)) >>> 1;
                    else if (pre_shape == fctl_pkg::SHAPE_LINEAR)
                        v = 32768 - longint'((longint'(i) * 32768) / w);
                    else
                        v = quarter_sine(65536 - u);
                end
                pre_tbl[i] = v[15:0];
            end
        end
    endfunction

    // Note an accepted input word and queue the level pair it should produce.
    function void note_item(fctl_pkg::fctl_item_t it);
        fctl_pkg::fctl_result_t lv;
        longint unsigned ph, pos, idx, f, a, b;
        lv = '0;
        if (it.cmd == fctl_pkg::CMD_REBUILD) begin
            rebuild_tables();
            rebuilds++;
        end else begin
            ph = it.phase;
            if (ph > 65536) ph = 65536;
            pos = ph * (N - 1);
            idx = pos >> 16;
            f = pos & 16'hFFFF;
            if (idx >= N - 1) begin
                idx = N - 2;
                f = 65536;
            end
            a = (longint'(rec_tbl[idx]) * (65536 - f) + longint'(rec_tbl[idx + 1]) * f) >> 16;
            b = (longint'(pre_tbl[idx]) * (65536 - f) + longint'(pre_tbl[idx + 1]) * f) >> 16;
            lv.rec_level = a[15:0];
            lv.pre_level = b[15:0];
            lookups++;
        end
        level_q.push_back(lv);
    endfunction

    // Compare an accepted result word with the oldest expected one.
    function void check_result(fctl_pkg::fctl_result_t got);
        fctl_pkg::fctl_result_t exp_lv;
        if (level_q.size() == 0) begin
            $display("%0t: unexpected result rec=%0d pre=%0d", $time,
                     got.rec_level, got.pre_level);
            errors++;
            return;
        end
        exp_lv = level_q.pop_front();
        if (got.rec_level !== exp_lv.rec_level) begin
            $display("%0t: rec_level expected %0d actual %0d", $time,
                     exp_lv.rec_level, got.rec_level);
            errors++;
        end
        if (got.pre_level !== exp_lv.pre_level) begin
            $display("%0t: pre_level expected %0d actual %0d", $time,
                     exp_lv.pre_level, got.pre_level);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import fctl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Index that maps to no register.
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         item_valid = 1'b0;
    logic         item_ready;
    fctl_item_t   item = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    fctl_result_t result;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    fade_scoreboard levels = new();
    bit idle_on = 1'b1;
    int stall_left = 0;

    fade_curve_table_lookup uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Watch both channels and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            levels.note_item(item);
        if (rst_n && result_valid && result_ready)
            levels.check_result(result);
    end

    // Result side stalls in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            result_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            result_ready <= 1'b0;
        end else begin
            result_ready <= 1'b1;
        end
    end

    // Present one word, with an optional gap before it, and wait for acceptance.
    task automatic send_word(logic cmd, logic [16:0] ph);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{cmd: cmd, phase: ph};
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    // Stop sending and let every expected word come back.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (levels.level_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        levels.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(logic [1:0] rs, logic [1:0] ps, logic [15:0] dmin,
                           logic [15:0] dratio, logic [15:0] wmin, logic [15:0] wratio);
        write_reg(CFG_REC_SHAPE, {14'd0, rs});
        write_reg(CFG_PRE_SHAPE, {14'd0, ps});
        write_reg(CFG_REC_DELAY_MIN, dmin);
        write_reg(CFG_REC_DELAY_RATIO, dratio);
        write_reg(CFG_PRE_WINDOW_MIN, wmin);
        write_reg(CFG_PRE_WINDOW_RATIO, wratio);
    endtask

    // Edge phases: zero, one, all ones and one half.
    task automatic edge_lookups();
        send_word(CMD_LOOKUP, 17'd0);
        send_word(CMD_LOOKUP, 17'd65536);
        send_word(CMD_LOOKUP, 17'h1FFFF);
        send_word(CMD_LOOKUP, 17'd32768);
    endtask

    function automatic logic [15:0] pick_min();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'd1024;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 64));
        endcase
    endfunction

    function automatic logic [16:0] pick_phase();
        case ($urandom_range(0, 9))
            0: return 17'd65536;
            1: return 17'($urandom_range(65537, 131071));
            2: return 17'($urandom_range(0, 3));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings first, so both tables are written.
        send_word(CMD_REBUILD, 17'h1FFFF);
        edge_lookups();
        send_word(CMD_LOOKUP, 17'd65535);
        drain();
        // Sine curves, no delay, widest window by ratio; unused index ignored.
        set_all(SHAPE_SINE, SHAPE_SINE, 16'd0, 16'd0, 16'd0, 16'd65535);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_word(CMD_REBUILD, 17'd0);
        edge_lookups();
        drain();
        // Linear record with delay clamped, raised preserve with window clamped.
        set_all(SHAPE_LINEAR, SHAPE_RAISED, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        send_word(CMD_REBUILD, 17'd1);
        edge_lookups();
        drain();
        // Record table kept; preserve window clamped up to one entry.
        set_all(SHAPE_KEEP, SHAPE_LINEAR, 16'd0, 16'd65535, 16'd0, 16'd0);
        send_word(CMD_REBUILD, 17'd0);
        edge_lookups();
        drain();
        // Preserve table kept; raised record with the longest ratio delay.
        set_all(SHAPE_RAISED, SHAPE_KEEP, 16'd0, 16'd65535, 16'd1024, 16'd0);
        send_word(CMD_REBUILD, 17'd0);
        edge_lookups();
        drain();

        // Random phases: new settings, a rebuild, then mostly lookups.
        for (int p = 0; p < 8; p++) begin
            if (p == 7) idle_on = 1'b0;
            set_all(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_min(),
                    16'($urandom_range(0, 65535)), pick_min(),
                    16'($urandom_range(0, 65535)));
            send_word(CMD_REBUILD, 17'($urandom_range(0, 131071)));
            for (int k = 0; k < 70; k++) begin
                if ($urandom_range(0, 60) == 0)
                    send_word(CMD_REBUILD, 17'($urandom_range(0, 131071)));
                else
                    send_word(CMD_LOOKUP, pick_phase());
                if (k == 35 && p % 2 == 0) drain();
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d rebuilds and %0d lookups over all shapes and clamps.",
                 levels.rebuilds, levels.lookups);
        $display("Sender and receiver idled in random bursts, none in the last phase.");
        if (levels.errors == 0 && levels.level_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire
